FILE: hdl/ppmfd_pkg.sv
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Shared constants, register map, and state types of the PPM frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmfd_pkg;

  localparam int unsigned MAX_CHANNELS = 20;
  localparam int unsigned IDX_W        = $clog2(MAX_CHANNELS);

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned HOLD_W  = 4;
  localparam int unsigned BOUND_W = 16;
  localparam int unsigned CHIDX_W = 5;
  localparam int unsigned CHVAL_W = 12;
  localparam int unsigned FLEN_W  = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [CHVAL_W-1:0] CHAN_VAL_MAX = '1;

  localparam logic [BOUND_W-1:0] RST_MIN_PULSE = 16'd200;
  localparam logic [BOUND_W-1:0] RST_MAX_PULSE = 16'd600;
  localparam logic [BOUND_W-1:0] RST_MIN_CHAN  = 16'd800;
  localparam logic [BOUND_W-1:0] RST_MAX_CHAN  = 16'd2200;
  localparam logic [BOUND_W-1:0] RST_START_GAP = 16'd2300;
  localparam logic [CNT_W-1:0]   RST_MIN_CHCNT = 6'd5;
  localparam logic [HOLD_W-1:0]  RST_LOCK      = 4'd4;

  localparam logic [2:0] REG_MIN_PULSE = 3'd0;
  localparam logic [2:0] REG_MAX_PULSE = 3'd1;
  localparam logic [2:0] REG_MIN_CHAN  = 3'd2;
  localparam logic [2:0] REG_MAX_CHAN  = 3'd3;
  localparam logic [2:0] REG_START_GAP = 3'd4;
  localparam logic [2:0] REG_MIN_CHCNT = 3'd5;
  localparam logic [2:0] REG_LOCK      = 3'd6;

  typedef enum logic [1:0] {
    PH_UNSYNC,
    PH_ARM,
    PH_ACTIVE,
    PH_INACTIVE
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_GAP,
    ST_PLO,
    ST_PHI,
    ST_FLEN,
    ST_IV,
    ST_CLO,
    ST_CHI,
    ST_ERR,
    ST_FRAME,
    ST_STATUS,
    ST_RD,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/ppmfd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmfd_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 20
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/ppmfd_sub.sv
// ----------------------------------------------------------------------------
// PPM frame decoder shared subtractor
// Wrapping 32-bit difference with borrow, used for gaps and bound compares.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmfd_sub (
  input  wire logic [ppmfd_pkg::TIME_W-1:0] a_i,
  input  wire logic [ppmfd_pkg::TIME_W-1:0] b_i,
  output logic      [ppmfd_pkg::TIME_W-1:0] diff_o,
  output logic                              borrow_o
);
  import ppmfd_pkg::*;

  logic [TIME_W:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[TIME_W-1:0];
  assign borrow_o = full[TIME_W];

endmodule

`default_nettype wire

FILE: hdl/ppm_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// PPM frame decoder
// Decodes a pulse-position stream from edge capture times into channel values.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                      Payload
//  in        sink       in_valid_i / in_ready_o        edge_time_i
//  out       source     out_valid_o / out_ready_i      frame_ok_o .. last_o
//  cfg       APB slave  psel / penable / pready        paddr, pwdata, prdata
//
//  An edge is accepted in the idle state and then steps through states that
//  each do at most one subtract or compare in the shared subtractor, ending
//  with a load of the status transaction or, at a frame end, channel output.
//  A frame end emits its channels one at a time, each read from the RAM read port first.
//  Reset clears all control state; channel RAM contents are not cleared.
//  A stalled output holds the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_frame_decoder_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [ppmfd_pkg::TIME_W-1:0]       edge_time_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    frame_ok_o,
  output logic      [ppmfd_pkg::CHIDX_W-1:0]      channel_index_o,
  output logic      [ppmfd_pkg::CHVAL_W-1:0]      channel_value_o,
  output logic      [ppmfd_pkg::CNT_W-1:0]        decoded_channels_o,
  output logic      [ppmfd_pkg::FLEN_W-1:0]       frame_length_o,
  output logic                                    sync_lost_o,
  output logic                                    last_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ppmfd_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [ppmfd_pkg::DATA_W-1:0]       pwdata,
  output logic      [ppmfd_pkg::DATA_W-1:0]       prdata,
  output logic                                    pready
);
  import ppmfd_pkg::*;

  logic [BOUND_W-1:0] min_pulse_q, max_pulse_q, min_chan_q, max_chan_q, start_gap_q;
  logic [CNT_W-1:0]   min_chcnt_q;
  logic [HOLD_W-1:0]  lock_q;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q <= RST_MIN_PULSE;
      max_pulse_q <= RST_MAX_PULSE;
      min_chan_q  <= RST_MIN_CHAN;
      max_chan_q  <= RST_MAX_CHAN;
      start_gap_q <= RST_START_GAP;
      min_chcnt_q <= RST_MIN_CHCNT;
      lock_q      <= RST_LOCK;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_PULSE: min_pulse_q <= pwdata[BOUND_W-1:0];
        REG_MAX_PULSE: max_pulse_q <= pwdata[BOUND_W-1:0];
        REG_MIN_CHAN:  min_chan_q  <= pwdata[BOUND_W-1:0];
        REG_MAX_CHAN:  max_chan_q  <= pwdata[BOUND_W-1:0];
        REG_START_GAP: start_gap_q <= pwdata[BOUND_W-1:0];
        REG_MIN_CHCNT: min_chcnt_q <= pwdata[CNT_W-1:0];
        REG_LOCK:      lock_q      <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MIN_PULSE: prdata = DATA_W'(min_pulse_q);
      REG_MAX_PULSE: prdata = DATA_W'(max_pulse_q);
      REG_MIN_CHAN:  prdata = DATA_W'(min_chan_q);
      REG_MAX_CHAN:  prdata = DATA_W'(max_chan_q);
      REG_START_GAP: prdata = DATA_W'(start_gap_q);
      REG_MIN_CHCNT: prdata = DATA_W'(min_chcnt_q);
      REG_LOCK:      prdata = DATA_W'(lock_q);
      default:       prdata = '0;
    endcase
  end

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [TIME_W-1:0]  t_q, t_d, val_q, val_d;
  logic [TIME_W-1:0]  prev_edge_q, prev_edge_d, prev_mark_q, prev_mark_d;
  logic [TIME_W-1:0]  frame_start_q, frame_start_d;
  logic [CNT_W-1:0]   fill_q, fill_d, adopted_q, adopted_d, cand_q, cand_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;
  logic [FLEN_W-1:0]  flen_q, flen_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               lost_q, lost_d;

  logic               ov_q, ov_d, ok_q, ok_d, olost_q, olost_d, olast_q, olast_d;
  logic [CHIDX_W-1:0] oidx_q, oidx_d;
  logic [CHVAL_W-1:0] oval_q, oval_d;
  logic [CNT_W-1:0]   odec_q, odec_d;
  logic [FLEN_W-1:0]  oflen_q, oflen_d;

  logic [TIME_W-1:0]  sub_a, sub_b, sub_diff;
  logic               sub_borrow;
  logic               can_load, emit_last;
  logic               ram_we;
  logic [CHVAL_W-1:0] ram_wdata, ram_rdata;

  ppmfd_sub u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  ppmfd_ram #(
    .WIDTH (CHVAL_W),
    .DEPTH (MAX_CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = (val_q[TIME_W-1:CHVAL_W] != '0) ? CHAN_VAL_MAX : val_q[CHVAL_W-1:0];
  assign can_load  = !ov_q || out_ready_i;
  assign emit_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    t_d           = t_q;
    val_d         = val_q;
    prev_edge_d   = prev_edge_q;
    prev_mark_d   = prev_mark_q;
    frame_start_d = frame_start_q;
    fill_d        = fill_q;
    adopted_d     = adopted_q;
    cand_d        = cand_q;
    cnt_d         = cnt_q;
    hold_d        = hold_q;
    flen_d        = flen_q;
    idx_d         = idx_q;
    lost_d        = lost_q;
    ov_d          = ov_q && !out_ready_i;
    ok_d          = ok_q;
    oidx_d        = oidx_q;
    oval_d        = oval_q;
    odec_d        = odec_q;
    oflen_d       = oflen_q;
    olost_d       = olost_q;
    olast_d       = olast_q;
    sub_a         = t_q;
    sub_b         = prev_edge_q;
    ram_we        = 1'b0;
    in_ready_o    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          t_d     = edge_time_i;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        val_d   = sub_diff;
        lost_d  = 1'b0;
        state_d = ST_GAP;
      end
      ST_GAP: begin
        sub_a = val_q;
        sub_b = TIME_W'(start_gap_q);
        if (!sub_borrow) begin
          state_d = ST_FRAME;
        end else begin
          case (phase_q)
            PH_ARM, PH_INACTIVE: state_d = ST_PLO;
            PH_ACTIVE:           state_d = ST_IV;
            default: begin
              prev_edge_d = t_q;
              state_d     = ST_STATUS;
            end
          endcase
        end
      end
      ST_PLO: begin
        sub_a   = val_q;
        sub_b   = TIME_W'(min_pulse_q);
        state_d = sub_borrow ? ST_ERR : ST_PHI;
      end
      ST_PHI: begin
        sub_a = TIME_W'(max_pulse_q);
        sub_b = val_q;
        if (sub_borrow) begin
          state_d = ST_ERR;
        end else if (phase_q == PH_ARM) begin
          state_d = ST_FLEN;
        end else begin
          phase_d     = PH_ACTIVE;
          prev_edge_d = t_q;
          state_d     = ST_STATUS;
        end
      end
      ST_FLEN: begin
        sub_a         = prev_edge_q;
        sub_b         = frame_start_q;
        flen_d        = sub_diff[FLEN_W-1:0];
        prev_mark_d   = prev_edge_q;
        frame_start_d = prev_edge_q;
        phase_d       = PH_ACTIVE;
        prev_edge_d   = t_q;
        state_d       = ST_STATUS;
      end
      ST_IV: begin
        sub_a       = t_q;
        sub_b       = prev_mark_q;
        val_d       = sub_diff;
        prev_mark_d = t_q;
        state_d     = ST_CLO;
      end
      ST_CLO: begin
        sub_a   = val_q;
        sub_b   = TIME_W'(min_chan_q);
        state_d = sub_borrow ? ST_ERR : ST_CHI;
      end
      ST_CHI: begin
        sub_a = TIME_W'(max_chan_q);
        sub_b = val_q;
        if (sub_borrow) begin
          state_d = ST_ERR;
        end else begin
          if (fill_q < CNT_W'(MAX_CHANNELS)) begin
            ram_we = 1'b1;
            fill_d = fill_q + CNT_W'(1);
          end
          phase_d     = PH_INACTIVE;
          prev_edge_d = t_q;
          state_d     = ST_STATUS;
        end
      end
      ST_ERR: begin
        phase_d   = PH_UNSYNC;
        adopted_d = '0;
        lost_d    = 1'b1;
        state_d   = ST_STATUS;
      end
      ST_FRAME: begin
        cnt_d = '0;
        if (fill_q != adopted_q) begin
          if (cand_q != fill_q) begin
            cand_d = fill_q;
            hold_d = lock_q;
          end else if (hold_q != '0) begin
            hold_d = hold_q - HOLD_W'(1);
          end else begin
            adopted_d = cand_q;
            cand_d    = '0;
          end
        end else if (fill_q >= min_chcnt_q) begin
          cnt_d = fill_q;
        end
        idx_d       = '0;
        fill_d      = '0;
        phase_d     = PH_ARM;
        prev_edge_d = t_q;
        state_d     = (cnt_d != '0) ? ST_RD : ST_STATUS;
      end
      ST_STATUS: begin
        if (can_load) begin
          ov_d    = 1'b1;
          ok_d    = 1'b0;
          oidx_d  = '0;
          oval_d  = '0;
          odec_d  = adopted_q;
          oflen_d = flen_q;
          olost_d = lost_q;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          ov_d    = 1'b1;
          ok_d    = 1'b1;
          oidx_d  = CHIDX_W'(idx_q);
          oval_d  = ram_rdata;
          odec_d  = adopted_q;
          oflen_d = flen_q;
          olost_d = 1'b0;
          olast_d = emit_last;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_UNSYNC;
      prev_edge_q   <= '0;
      prev_mark_q   <= '0;
      frame_start_q <= '0;
      fill_q        <= '0;
      adopted_q     <= '0;
      cand_q        <= '0;
      hold_q        <= '0;
      flen_q        <= '0;
      cnt_q         <= '0;
      idx_q         <= '0;
      ov_q          <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      prev_edge_q   <= prev_edge_d;
      prev_mark_q   <= prev_mark_d;
      frame_start_q <= frame_start_d;
      fill_q        <= fill_d;
      adopted_q     <= adopted_d;
      cand_q        <= cand_d;
      hold_q        <= hold_d;
      flen_q        <= flen_d;
      cnt_q         <= cnt_d;
      idx_q         <= idx_d;
      ov_q          <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    val_q   <= val_d;
    lost_q  <= lost_d;
    ok_q    <= ok_d;
    oidx_q  <= oidx_d;
    oval_q  <= oval_d;
    odec_q  <= odec_d;
    oflen_q <= oflen_d;
    olost_q <= olost_d;
    olast_q <= olast_d;
  end

  assign out_valid_o        = ov_q;
  assign frame_ok_o         = ok_q;
  assign channel_index_o    = oidx_q;
  assign channel_value_o    = oval_q;
  assign decoded_channels_o = odec_q;
  assign frame_length_o     = oflen_q;
  assign sync_lost_o        = olost_q;
  assign last_o             = olast_q;

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_ok_o) |-> last_o)
    else $error("Status transaction without last.");

  a_lost_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sync_lost_o) |-> (decoded_channels_o == '0))
    else $error("Sync loss reported with nonzero channel count.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Input accepted while an edge is in progress.");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_CHANNELS))
    else $error("Channel fill beyond store depth.");

endmodule

`default_nettype wire

FILE: tb/sv/ppm_frame_decoder_top_test.sv
// ----------------------------------------------------------------------------
// PPM frame decoder testbench
// Drives edge capture times into the decoder through its valid/ready input
// channel while the output channel stalls at random. A behavioral decoder in
// the bench predicts every result transaction, and a monitor compares each
// field of each result against it. Directed tests cover reset values, the
// register file, channel-count lock-in, sync errors and bound extremes.
// Random tests then run well-formed frames with random content, interleaved
// with broken frames and noise edges, under several register settings.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_top_test;
  import ppmfd_pkg::*;

  localparam logic [2:0]  REG_UNUSED    = 3'd7;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef enum int {
    FAULT_NONE,
    FAULT_ARM_PULSE,
    FAULT_INTERVAL,
    FAULT_GAP_PULSE
  } fault_e;

  typedef struct packed {
    logic               frame_ok;
    logic [CHIDX_W-1:0] chan_idx;
    logic [CHVAL_W-1:0] chan_val;
    logic [CNT_W-1:0]   chans;
    logic [FLEN_W-1:0]  flen;
    logic               lost;
    logic               last;
  } decode_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [TIME_W-1:0]  edge_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               frame_ok_o;
  logic [CHIDX_W-1:0] channel_index_o;
  logic [CHVAL_W-1:0] channel_value_o;
  logic [CNT_W-1:0]   decoded_channels_o;
  logic [FLEN_W-1:0]  frame_length_o;
  logic               sync_lost_o;
  logic               last_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [ADDR_W-1:0]  paddr       = '0;
  logic [DATA_W-1:0]  pwdata      = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  logic [BOUND_W-1:0] min_pulse_q     = RST_MIN_PULSE;
  logic [BOUND_W-1:0] max_pulse_q     = RST_MAX_PULSE;
  logic [BOUND_W-1:0] min_chan_q      = RST_MIN_CHAN;
  logic [BOUND_W-1:0] max_chan_q      = RST_MAX_CHAN;
  logic [BOUND_W-1:0] start_gap_q     = RST_START_GAP;
  logic [CNT_W-1:0]   min_chcnt_q     = RST_MIN_CHCNT;
  logic [HOLD_W-1:0]  lock_frames_q   = RST_LOCK;

  logic [TIME_W-1:0]  prev_edge_q     = '0;
  logic [TIME_W-1:0]  prev_mark_q     = '0;
  logic [TIME_W-1:0]  frame_start_q   = '0;
  logic [CNT_W-1:0]   fill_q          = '0;
  phase_e             phase_q         = PH_UNSYNC;
  logic [CHVAL_W-1:0] chan_mem [MAX_CHANNELS];
  logic [CNT_W-1:0]   adopted_q       = '0;
  logic [CNT_W-1:0]   candidate_q     = '0;
  logic [HOLD_W-1:0]  holdoff_q       = '0;
  logic [FLEN_W-1:0]  frame_len_q     = '0;

  decode_result_t     decode_results_q [$];
  int unsigned        mismatch_count  = 0;
  int unsigned        edges_sent      = 0;
  logic [TIME_W-1:0]  edge_clock_q    = '0;
  bit                 idle_on         = 1'b1;

  ppm_frame_decoder_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .edge_time_i        (edge_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frame_ok_o         (frame_ok_o),
    .channel_index_o    (channel_index_o),
    .channel_value_o    (channel_value_o),
    .decoded_channels_o (decoded_channels_o),
    .frame_length_o     (frame_length_o),
    .sync_lost_o        (sync_lost_o),
    .last_o             (last_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic push_result(input logic ok, input logic [CHIDX_W-1:0] idx,
                             input logic [CHVAL_W-1:0] val, input logic lost,
                             input logic fin);
    decode_result_t r;
    r.frame_ok = ok;
    r.chan_idx = idx;
    r.chan_val = val;
    r.chans    = adopted_q;
    r.flen     = frame_len_q;
    r.lost     = lost;
    r.last     = fin;
    decode_results_q.push_back(r);
  endtask

  task automatic decode_edge(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] width;
    logic [TIME_W-1:0] span;
    int unsigned       emit_n;
    logic              lost;
    width = t - prev_edge_q;
    lost  = 1'b0;
    if (width >= TIME_W'(start_gap_q)) begin
      emit_n = 0;
      if (fill_q != adopted_q) begin
        if (candidate_q != fill_q) begin
          candidate_q = fill_q;
          holdoff_q   = lock_frames_q;
        end else if (holdoff_q != 0) begin
          holdoff_q--;
        end else begin
          adopted_q   = candidate_q;
          candidate_q = '0;
        end
      end else if (fill_q >= min_chcnt_q) begin
        emit_n = fill_q;
      end
      if (emit_n > MAX_CHANNELS) emit_n = MAX_CHANNELS;
      for (int unsigned i = 0; i < emit_n; i++) begin
        push_result(1'b1, CHIDX_W'(i), chan_mem[i], 1'b0, i + 1 == emit_n);
      end
      fill_q      = '0;
      phase_q     = PH_ARM;
      prev_edge_q = t;
      if (emit_n == 0) push_result(1'b0, '0, '0, 1'b0, 1'b1);
    end else begin
      case (phase_q)
        PH_ARM: begin
          if (width < min_pulse_q || width > max_pulse_q) begin
            lost = 1'b1;
          end else begin
            span          = prev_edge_q - frame_start_q;
            frame_len_q   = span[FLEN_W-1:0];
            prev_mark_q   = prev_edge_q;
            frame_start_q = prev_edge_q;
            phase_q       = PH_ACTIVE;
          end
        end
        PH_INACTIVE: begin
          if (width < min_pulse_q || width > max_pulse_q) begin
            lost = 1'b1;
          end else begin
            phase_q = PH_ACTIVE;
          end
        end
        PH_ACTIVE: begin
          span        = t - prev_mark_q;
          prev_mark_q = t;
          if (span < min_chan_q || span > max_chan_q) begin
            lost = 1'b1;
          end else begin
            if (fill_q < MAX_CHANNELS) begin
              chan_mem[fill_q] = (span > TIME_W'(CHAN_VAL_MAX)) ? CHAN_VAL_MAX
                                                                : span[CHVAL_W-1:0];
              fill_q++;
            end
            phase_q = PH_INACTIVE;
          end
        end
        default: ;
      endcase
      if (lost) begin
        phase_q   = PH_UNSYNC;
        adopted_q = '0;
      end else begin
        prev_edge_q = t;
      end
      push_result(1'b0, '0, '0, lost, 1'b1);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_pulse();
    int unsigned lo;
    int unsigned hi;
    lo = min_pulse_q;
    hi = max_pulse_q;
    if (hi < lo) return lo;
    if (hi > lo + 1000) hi = lo + 1000;
    return $urandom_range(lo, hi);
  endfunction

  function automatic int unsigned bad_pulse();
    if (min_pulse_q > 0 && $urandom_range(1) == 0) return $urandom_range(0, min_pulse_q - 1);
    return max_pulse_q + $urandom_range(1, 200);
  endfunction

  function automatic int unsigned pick_interval(input int unsigned pulse);
    int unsigned lo;
    int unsigned hi;
    lo = (min_chan_q > pulse) ? min_chan_q : pulse + 1;
    hi = max_chan_q;
    if (hi < lo) return lo;
    return $urandom_range(lo, hi);
  endfunction

  function automatic int unsigned bad_interval(input int unsigned pulse);
    if (min_chan_q > pulse + 1 && $urandom_range(1) == 0) begin
      return $urandom_range(pulse + 1, min_chan_q - 1);
    end
    return max_chan_q + $urandom_range(1, 200);
  endfunction

  task automatic send_edge(input logic [TIME_W-1:0] t);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    edge_time_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    decode_edge(t);
    edge_clock_q = t;
    edges_sent++;
  endtask

  task automatic send_frame(input int unsigned chans, input fault_e fault);
    logic [TIME_W-1:0] mark;
    int unsigned       pulse;
    int unsigned       bad_at;
    bad_at = (chans > 0) ? $urandom_range(chans - 1) : 0;
    send_edge(edge_clock_q + start_gap_q + $urandom_range(0, 3000));
    mark  = edge_clock_q;
    pulse = (fault == FAULT_ARM_PULSE) ? bad_pulse() : pick_pulse();
    send_edge(mark + pulse);
    for (int unsigned c = 0; c < chans; c++) begin
      mark += (fault == FAULT_INTERVAL && c == bad_at) ? bad_interval(pulse)
                                                       : pick_interval(pulse);
      send_edge(mark);
      if (c + 1 < chans || fault != FAULT_NONE || $urandom_range(1) == 0) begin
        pulse = (fault == FAULT_GAP_PULSE && c == bad_at) ? bad_pulse() : pick_pulse();
        send_edge(mark + pulse);
      end
    end
  endtask

  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decode_results_q.size() != 0);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored;
    stored = '0;
    case (idx)
      REG_MIN_PULSE: begin
        min_pulse_q = value[BOUND_W-1:0];
        stored      = DATA_W'(min_pulse_q);
      end
      REG_MAX_PULSE: begin
        max_pulse_q = value[BOUND_W-1:0];
        stored      = DATA_W'(max_pulse_q);
      end
      REG_MIN_CHAN: begin
        min_chan_q = value[BOUND_W-1:0];
        stored     = DATA_W'(min_chan_q);
      end
      REG_MAX_CHAN: begin
        max_chan_q = value[BOUND_W-1:0];
        stored     = DATA_W'(max_chan_q);
      end
      REG_START_GAP: begin
        start_gap_q = value[BOUND_W-1:0];
        stored      = DATA_W'(start_gap_q);
      end
      REG_MIN_CHCNT: begin
        min_chcnt_q = value[CNT_W-1:0];
        stored      = DATA_W'(min_chcnt_q);
      end
      REG_LOCK: begin
        lock_frames_q = value[HOLD_W-1:0];
        stored        = DATA_W'(lock_frames_q);
      end
      default: ;
    endcase
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx != REG_UNUSED) check_field("register readback", stored, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input int unsigned minp, maxp, minc, maxc, gap, chans,
                              lock_n);
    write_register(REG_MIN_PULSE, minp);
    write_register(REG_MAX_PULSE, maxp);
    write_register(REG_MIN_CHAN, minc);
    write_register(REG_MAX_CHAN, maxc);
    write_register(REG_START_GAP, gap);
    write_register(REG_MIN_CHCNT, chans);
    write_register(REG_LOCK, lock_n);
  endtask

  // The first edge after reset sees a zero gap, the second spans the whole time range.
  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_edge('0);
    send_edge('1);
    send_frame(1, FAULT_NONE);
  endtask

  task automatic test_register_file();
    drain_decoder();
    for (int i = 0; i <= REG_UNUSED; i++) write_register(3'(i), '1);
    for (int i = 0; i <= REG_UNUSED; i++) write_register(3'(i), '0);
    apply_config(RST_MIN_PULSE, RST_MAX_PULSE, RST_MIN_CHAN, RST_MAX_CHAN,
                 RST_START_GAP, RST_MIN_CHCNT, RST_LOCK);
  endtask

  task automatic test_lock_and_emit();
    drain_decoder();
    apply_config(RST_MIN_PULSE, RST_MAX_PULSE, RST_MIN_CHAN, RST_MAX_CHAN,
                 RST_START_GAP, 1, 0);
    edge_clock_q = 32'hFFFF_C000;
    repeat (4) send_frame(2, FAULT_NONE);
    send_edge(edge_clock_q + start_gap_q);
  endtask

  task automatic test_sync_errors();
    send_frame(2, FAULT_ARM_PULSE);
    send_frame(2, FAULT_INTERVAL);
    send_frame(2, FAULT_GAP_PULSE);
    send_edge(edge_clock_q + start_gap_q);
  endtask

  task automatic test_bound_extremes();
    drain_decoder();
    apply_config(RST_MAX_PULSE, RST_MIN_PULSE, RST_MAX_CHAN, RST_MIN_CHAN,
                 RST_START_GAP, 1, 0);
    repeat (2) send_frame(1, FAULT_NONE);
    drain_decoder();
    apply_config(RST_MIN_PULSE, RST_MAX_PULSE, RST_MIN_CHAN, RST_MAX_CHAN, 0, 32, 15);
    repeat (4) send_edge($urandom);
    drain_decoder();
    write_register(REG_START_GAP, RST_START_GAP);
    repeat (2) send_frame(2, FAULT_NONE);
  endtask

  // Frames longer than the channel store, with intervals well past the 12-bit range.
  task automatic test_long_frames();
    drain_decoder();
    apply_config(0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, MAX_CHANNELS, 0);
    idle_on = 1'b0;
    repeat (3) send_frame(MAX_CHANNELS + 1, FAULT_NONE);
    send_edge(edge_clock_q + start_gap_q);
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned phase_end;
    int unsigned base_chans;
    int unsigned roll;
    int unsigned minp;
    int unsigned maxp;
    int unsigned minc;
    int unsigned maxc;
    for (int p = 0; p < 5; p++) begin
      drain_decoder();
      minp       = $urandom_range(50, 400);
      maxp       = minp + $urandom_range(0, 300);
      minc       = maxp + $urandom_range(1, 600);
      maxc       = minc + $urandom_range(0, 3000);
      base_chans = $urandom_range(1, 8);
      apply_config(minp, maxp, minc, maxc, maxc + $urandom_range(1, 2000),
                   $urandom_range(1, base_chans + 1), $urandom_range(0, 3));
      idle_on      = (p != 2);
      edge_clock_q = $urandom;
      phase_end    = edges_sent + 28;
      while (edges_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          send_frame(base_chans, FAULT_NONE);
        end else if (roll < 83) begin
          send_frame($urandom_range(0, MAX_CHANNELS + 2), FAULT_NONE);
        end else if (roll < 91) begin
          send_frame(base_chans, fault_e'($urandom_range(FAULT_ARM_PULSE, FAULT_GAP_PULSE)));
        end else if (roll < 97) begin
          send_edge($urandom);
        end else begin
          drain_decoder();
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    forever begin
      if (idle_on && $urandom_range(3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3))
          @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    decode_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decode_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transaction, expected none, actual index %0d",
                 $time, channel_index_o);
      end else begin
        want = decode_results_q.pop_front();
        check_field("frame_ok", want.frame_ok, frame_ok_o);
        check_field("channel_index", want.chan_idx, channel_index_o);
        check_field("channel_value", want.chan_val, channel_value_o);
        check_field("decoded_channels", want.chans, decoded_channels_o);
        check_field("frame_length", want.flen, frame_length_o);
        check_field("sync_lost", want.lost, sync_lost_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ppm_frame_decoder_top test failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_file();
    test_lock_and_emit();
    test_sync_errors();
    test_bound_extremes();
    test_long_frames();
    test_random_frames();
    drain_decoder();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && decode_results_q.size() == 0) begin
      $display("ppm_frame_decoder_top test passed");
    end else begin
      $display("ppm_frame_decoder_top test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ppmfd_pkg.sv
hdl/ppmfd_ram.sv
hdl/ppmfd_sub.sv
hdl/ppm_frame_decoder_top.sv
tb/sv/ppm_frame_decoder_top_test.sv
